FILE: rtl/udivmod_128_core_assert.svh
// Assertion macros used by the checker file of the divider core.
`ifndef UDIVMOD_128_CORE_ASSERT_SVH
`define UDIVMOD_128_CORE_ASSERT_SVH

// Checked at every clock edge outside reset.
`define UDM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("udivmod_128_core: assertion failed");

// Checked at every clock edge, reset included.
`define UDM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("udivmod_128_core: assertion failed");

`endif

FILE: rtl/udm_pkg.sv
// Types and constants shared by the 128-bit divider modules.
package udm_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned DATA_W = 2 * WORD_W;
  localparam int unsigned CNT_W  = $clog2(DATA_W);

  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_W - 1);

  typedef struct packed {
    logic load;
    logic step;
    logic capture;
  } udm_cmd_t;

  typedef struct packed {
    logic div_zero;
  } udm_sts_t;

endpackage

FILE: rtl/udm_in_if.sv
// Input channel of the divider: dividend and divisor halves with valid and ready.
interface udm_in_if;
  import udm_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] dividend_high;
  logic [WORD_W-1:0] dividend_low;
  logic [WORD_W-1:0] divisor_high;
  logic [WORD_W-1:0] divisor_low;

  modport source (
    output valid, dividend_high, dividend_low, divisor_high, divisor_low,
    input  ready
  );

  modport sink (
    input  valid, dividend_high, dividend_low, divisor_high, divisor_low,
    output ready
  );

endinterface

FILE: rtl/udm_out_if.sv
// Output channel of the divider: quotient, remainder and flag with valid and ready.
interface udm_out_if;
  import udm_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] quotient_high;
  logic [WORD_W-1:0] quotient_low;
  logic [WORD_W-1:0] remainder_high;
  logic [WORD_W-1:0] remainder_low;
  logic              divide_by_zero;

  modport source (
    output valid, quotient_high, quotient_low, remainder_high, remainder_low,
           divide_by_zero,
    input  ready
  );

  modport sink (
    input  valid, quotient_high, quotient_low, remainder_high, remainder_low,
           divide_by_zero,
    output ready
  );

endinterface

FILE: rtl/udivmod_128_core.sv
// Top level of the unsigned 128-bit divider with remainder.
// An input transfer is loaded and followed by 128 serial shift-subtract steps of the single
// 130-bit subtractor and a capture into the result register; a zero divisor skips the steps.
// A new item is taken only after the result of the last one has been captured.
// The result register holds a finished result while the next item is taken.
// Reset is asynchronous and active low; it clears the controller and the valid flags.
module udivmod_128_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  udm_in_if.sink          in_i,
  udm_out_if.source       out_o
);
  import udm_pkg::*;

  udm_cmd_t          cmd;
  udm_sts_t          sts;
  logic [DATA_W-1:0] quotient;
  logic [DATA_W-1:0] remainder;
  logic              div_zero;

  udm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  udm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .dividend_i  ({in_i.dividend_high, in_i.dividend_low}),
    .divisor_i   ({in_i.divisor_high, in_i.divisor_low}),
    .quotient_o  (quotient),
    .remainder_o (remainder),
    .div_zero_o  (div_zero)
  );

  assign out_o.quotient_high  = quotient[DATA_W-1:WORD_W];
  assign out_o.quotient_low   = quotient[WORD_W-1:0];
  assign out_o.remainder_high = remainder[DATA_W-1:WORD_W];
  assign out_o.remainder_low  = remainder[WORD_W-1:0];
  assign out_o.divide_by_zero = div_zero;

endmodule

FILE: rtl/udm_dp.sv
// Datapath of the divider: restoring shift-subtract registers and the result register.
module udm_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  udm_pkg::udm_cmd_t         cmd_i,
  output udm_pkg::udm_sts_t         sts_o,
  input  logic [udm_pkg::DATA_W-1:0] dividend_i,
  input  logic [udm_pkg::DATA_W-1:0] divisor_i,
  output logic [udm_pkg::DATA_W-1:0] quotient_o,
  output logic [udm_pkg::DATA_W-1:0] remainder_o,
  output logic                      div_zero_o
);
  import udm_pkg::*;

  logic [DATA_W-1:0] rem_q, rem_d;
  logic [DATA_W-1:0] nq_q, nq_d;
  logic [DATA_W-1:0] div_q, div_d;
  logic              dz_q, dz_d;
  logic [DATA_W-1:0] quo_out_q;
  logic [DATA_W-1:0] rem_out_q;
  logic              dz_out_q;

  logic [DATA_W:0]   shifted;
  logic [DATA_W+1:0] diff;
  logic              take;

  // The partial remainder grows to one bit more than the operands before the subtract.
  assign shifted = {rem_q, nq_q[DATA_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, div_q};
  assign take    = ~diff[DATA_W+1];

  always_comb begin
    rem_d = rem_q;
    nq_d  = nq_q;
    div_d = div_q;
    dz_d  = dz_q;
    if (cmd_i.load) begin
      rem_d = '0;
      nq_d  = dividend_i;
      div_d = divisor_i;
      dz_d  = (divisor_i == '0);
    end else if (cmd_i.step) begin
      rem_d = take ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
      nq_d  = {nq_q[DATA_W-2:0], take};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q <= 1'b0;
    end else begin
      dz_q <= dz_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    nq_q  <= nq_d;
    div_q <= div_d;
    if (cmd_i.capture) begin
      if (dz_q) begin
        quo_out_q <= '1;
        rem_out_q <= {{WORD_W{1'b0}}, {WORD_W{1'b1}}};
      end else begin
        quo_out_q <= nq_q;
        rem_out_q <= rem_q;
      end
      dz_out_q <= dz_q;
    end
  end

  assign sts_o.div_zero = dz_q;
  assign quotient_o     = quo_out_q;
  assign remainder_o    = rem_out_q;
  assign div_zero_o     = dz_out_q;

endmodule

FILE: rtl/udm_ctrl.sv
// Controller of the divider: sequences load, 128 steps and the result transfer.
module udm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  udm_pkg::udm_sts_t sts_i,
  output udm_pkg::udm_cmd_t cmd_o
);
  import udm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic             in_ready_q;
  logic             out_valid_q;

  always_comb begin
    cmd_o.load    = (state_q == ST_IDLE) && in_valid_i && in_ready_q;
    cmd_o.step    = (state_q == ST_RUN) && !sts_i.div_zero;
    cmd_o.capture = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.capture) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (cmd_o.load) begin
            state_q    <= ST_RUN;
            cnt_q      <= '0;
            in_ready_q <= 1'b0;
          end
        end
        ST_RUN: begin
          // A zero divisor needs no steps, its result is fixed.
          if (sts_i.div_zero || cnt_q == LAST_STEP) begin
            state_q <= ST_FINISH;
          end
          cnt_q <= cnt_q + 1'b1;
        end
        ST_FINISH: begin
          if (cmd_o.capture) begin
            state_q    <= ST_IDLE;
            in_ready_q <= 1'b1;
          end
        end
        default: begin
          state_q    <= ST_IDLE;
          in_ready_q <= 1'b1;
        end
      endcase
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/udm_checker.sv
// Port-level assertion checker for the divider core and its bind statement.
`include "udivmod_128_core_assert.svh"

module udm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  udm_in_if.sink    in_i,
  udm_out_if.source out_o
);
  import udm_pkg::*;

  logic                out_stall;
  logic                dz_result_ok;
  logic [4*WORD_W:0]   out_payload;

  assign out_stall    = out_o.valid && !out_o.ready;
  assign dz_result_ok = (&out_o.quotient_high) && (&out_o.quotient_low) &&
                        (out_o.remainder_high == '0) && (&out_o.remainder_low);
  assign out_payload  = {out_o.quotient_high, out_o.quotient_low, out_o.remainder_high,
                         out_o.remainder_low, out_o.divide_by_zero};

  `UDM_ASSERT(a_out_valid_held, out_stall |=> out_o.valid)
  `UDM_ASSERT(a_out_payload_held, out_stall |=> $stable(out_payload))
  `UDM_ASSERT(a_one_item_in_work, in_i.valid && in_i.ready |=> !in_i.ready)
  `UDM_ASSERT(a_zero_divisor_result, out_o.valid && out_o.divide_by_zero |-> dz_result_ok)
  `UDM_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |-> !out_o.valid)

endmodule

bind udivmod_128_core udm_checker u_udm_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_i   (in_i),
  .out_o  (out_o)
);
